>>> design/json_string_unescape_utf8_top_defines.svh
// Assertion macros shared by the JSON string unescaper modules.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Clocked check, masked while reset is high.
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that must also hold during reset.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/jsu_pkg.sv
// Shared types, constants and helper functions of the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Command queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Code unit ranges
  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  // Sequence length codes (byte count minus one)
  localparam logic [1:0] LEN1 = 2'd0;
  localparam logic [1:0] LEN2 = 2'd1;
  localparam logic [1:0] LEN3 = 2'd2;
  localparam logic [1:0] LEN4 = 2'd3;

  // One command from the parser to the byte emitter
  typedef struct packed {
    logic        is_end;  // end-of-literal status result
    logic        err;     // status on an end command
    logic [1:0]  len_m1;  // output byte count minus one
    logic [20:0] cp;      // code point, or the raw byte for a single
  } cmd_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Byte idx of the output sequence for a command
  function automatic logic [7:0] seq_byte(input cmd_t c, input logic [1:0] idx);
    logic [7:0] r;
    r = 8'd0;
    case (c.len_m1)
      LEN1: r = c.cp[7:0];
      LEN2: begin
        case (idx)
          2'd0:    r = LEAD2 | {3'b000, c.cp[10:6]};
          default: r = CONT | {2'b00, c.cp[5:0]};
        endcase
      end
      LEN3: begin
        case (idx)
          2'd0:    r = LEAD3 | {4'b0000, c.cp[15:12]};
          2'd1:    r = CONT | {2'b00, c.cp[11:6]};
          default: r = CONT | {2'b00, c.cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    r = LEAD4 | {5'b00000, c.cp[20:18]};
          2'd1:    r = CONT | {2'b00, c.cp[17:12]};
          2'd2:    r = CONT | {2'b00, c.cp[11:6]};
          default: r = CONT | {2'b00, c.cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/jsu_front.sv
// Parser front end: accepts literal bytes, tracks escapes, issues commands.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          acc,
  input  wire logic [7:0]    data_byte,
  input  wire logic          literal_last,
  output jsu_pkg::cmd_t      cmd,
  output logic               cmd_push
);

  typedef enum logic [7:0] {
    PH_OPEN  = 8'b0000_0001,
    PH_BODY  = 8'b0000_0010,
    PH_ESC   = 8'b0000_0100,
    PH_HEX1  = 8'b0000_1000,
    PH_BSL2  = 8'b0001_0000,
    PH_U2    = 8'b0010_0000,
    PH_HEX2  = 8'b0100_0000,
    PH_DRAIN = 8'b1000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] high_unit, high_unit_next;
  logic [11:0] low_unit, low_unit_next;
  logic [1:0]  digit_count, digit_count_next;

  logic [4:0]  hex;
  logic [15:0] high_shift;
  logic [15:0] low_full;
  logic [4:0]  plane;

  // Digit assembly
  assign hex        = jsu_pkg::hex_value(data_byte);
  assign high_shift = {high_unit[11:0], hex[3:0]};
  assign low_full   = {low_unit, hex[3:0]};
  assign plane      = {1'b0, high_unit[9:6]} + 5'd1;

  // Next state and command
  always_comb begin
    phase_next       = phase;
    high_unit_next   = high_unit;
    low_unit_next    = low_unit;
    digit_count_next = digit_count;
    cmd_push         = 1'b0;
    cmd              = '0;
    if (acc) begin
      if (literal_last) begin
        cmd_push         = 1'b1;
        cmd.is_end       = 1'b1;
        cmd.err          = (phase != PH_BODY) || (data_byte != jsu_pkg::CH_QUOTE);
        phase_next       = PH_OPEN;
        high_unit_next   = '0;
        low_unit_next    = '0;
        digit_count_next = '0;
      end else begin
        case (phase)
          PH_OPEN: begin
            phase_next = (data_byte == jsu_pkg::CH_QUOTE) ? PH_BODY : PH_DRAIN;
          end
          PH_BODY: begin
            if (data_byte == jsu_pkg::CH_BSL) begin
              phase_next = PH_ESC;
            end else begin
              cmd_push  = 1'b1;
              cmd.cp    = {13'd0, data_byte};
            end
          end
          PH_ESC: begin
            phase_next = PH_BODY;
            cmd.len_m1 = jsu_pkg::LEN1;
            case (data_byte)
              jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: begin
                cmd_push = 1'b1;
                cmd.cp   = {13'd0, data_byte};
              end
              jsu_pkg::CH_B: begin
                cmd_push = 1'b1;
                cmd.cp   = {13'd0, jsu_pkg::CH_BS};
              end
              jsu_pkg::CH_F: begin
                cmd_push = 1'b1;
                cmd.cp   = {13'd0, jsu_pkg::CH_FF};
              end
              jsu_pkg::CH_N: begin
                cmd_push = 1'b1;
                cmd.cp   = {13'd0, jsu_pkg::CH_LF};
              end
              jsu_pkg::CH_R: begin
                cmd_push = 1'b1;
                cmd.cp   = {13'd0, jsu_pkg::CH_CR};
              end
              jsu_pkg::CH_T: begin
                cmd_push = 1'b1;
                cmd.cp   = {13'd0, jsu_pkg::CH_TAB};
              end
              jsu_pkg::CH_U: begin
                phase_next       = PH_HEX1;
                high_unit_next   = '0;
                digit_count_next = '0;
              end
              default: phase_next = PH_DRAIN;
            endcase
          end
          PH_HEX1: begin
            if (!hex[4]) begin
              phase_next = PH_DRAIN;
            end else begin
              high_unit_next = high_shift;
              if (digit_count == 2'd3) begin
                digit_count_next = '0;
                if (high_shift >= jsu_pkg::HI_SURR_MIN &&
                    high_shift <= jsu_pkg::HI_SURR_MAX) begin
                  phase_next = PH_BSL2;
                end else if (high_shift >= jsu_pkg::LO_SURR_MIN &&
                             high_shift <= jsu_pkg::LO_SURR_MAX) begin
                  phase_next = PH_DRAIN;
                end else begin
                  phase_next = PH_BODY;
                  cmd_push   = 1'b1;
                  cmd.cp     = {5'd0, high_shift};
                  if (high_shift <= jsu_pkg::ONE_BYTE_MAX) begin
                    cmd.len_m1 = jsu_pkg::LEN1;
                  end else if (high_shift <= jsu_pkg::TWO_BYTE_MAX) begin
                    cmd.len_m1 = jsu_pkg::LEN2;
                  end else begin
                    cmd.len_m1 = jsu_pkg::LEN3;
                  end
                end
              end else begin
                digit_count_next = digit_count + 2'd1;
              end
            end
          end
          PH_BSL2: begin
            phase_next = (data_byte == jsu_pkg::CH_BSL) ? PH_U2 : PH_DRAIN;
          end
          PH_U2: begin
            if (data_byte == jsu_pkg::CH_U) begin
              phase_next       = PH_HEX2;
              low_unit_next    = '0;
              digit_count_next = '0;
            end else begin
              phase_next = PH_DRAIN;
            end
          end
          PH_HEX2: begin
            if (!hex[4]) begin
              phase_next = PH_DRAIN;
            end else begin
              low_unit_next = low_full[11:0];
              if (digit_count == 2'd3) begin
                digit_count_next = '0;
                if (low_full >= jsu_pkg::LO_SURR_MIN &&
                    low_full <= jsu_pkg::LO_SURR_MAX) begin
                  // Supplementary code point from the surrogate pair
                  phase_next = PH_BODY;
                  cmd_push   = 1'b1;
                  cmd.len_m1 = jsu_pkg::LEN4;
                  cmd.cp     = {plane, high_unit[5:0], low_full[9:0]};
                end else begin
                  phase_next = PH_DRAIN;
                end
              end else begin
                digit_count_next = digit_count + 2'd1;
              end
            end
          end
          PH_DRAIN: phase_next = PH_DRAIN;
          default:  phase_next = PH_DRAIN;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OPEN;
      high_unit   <= '0;
      low_unit    <= '0;
      digit_count <= '0;
    end else begin
      phase       <= phase_next;
      high_unit   <= high_unit_next;
      low_unit    <= low_unit_next;
      digit_count <= digit_count_next;
    end
  end

  `JSU_ASSERT(a_end_restarts, acc && literal_last |=> phase == PH_OPEN, "phase not reset after end")
  `JSU_ASSERT(a_one_end_per_last, cmd_push && cmd.is_end |-> acc && literal_last, "end command without final byte")

endmodule

`default_nettype wire

>>> design/jsu_cmdq.sv
// Short command queue between the parser and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_cmdq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire jsu_pkg::cmd_t wr_cmd,
  output logic               q_full,
  input  wire logic          rd_en,
  output jsu_pkg::cmd_t      rd_cmd,
  output logic               q_valid
);

  jsu_pkg::cmd_t                entries [jsu_pkg::QUEUE_DEPTH];
  logic [jsu_pkg::QPTR_W-1:0]   wr_ptr;
  logic [jsu_pkg::QPTR_W-1:0]   rd_ptr;
  logic [jsu_pkg::QCNT_W-1:0]   count;
  logic                         do_wr, do_rd;

  assign q_full  = (count == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_cmd  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + jsu_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + jsu_pkg::QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + jsu_pkg::QCNT_W'(1);
        2'b01:   count <= count - jsu_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `JSU_ASSERT(a_count_bound, count <= jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH), "queue count overflow")
  `JSU_ASSERT(a_no_lost_write, wr_en |-> !q_full, "command written into a full queue")

endmodule

`default_nettype wire

>>> design/jsu_back.sv
// Byte emitter: expands queued commands into result transfers.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire jsu_pkg::cmd_t head,
  input  wire logic          head_valid,
  output logic               head_pop,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               run_last,
  output logic               literal_done,
  output logic               decode_error,
  output logic               empty,
  input  wire logic          pop
);

  logic       res_full;
  logic [1:0] idx;
  logic       load;
  logic       seq_end;

  assign empty    = !res_full;
  assign load     = !res_full || pop;
  assign seq_end  = head.is_end || (idx == head.len_m1);
  assign head_pop = load && head_valid && seq_end;

  // Result register and position within the current command
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      res_full <= head_valid;
      if (head_valid) begin
        idx <= seq_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte     <= head.is_end ? 8'd0 : jsu_pkg::seq_byte(head, idx);
      byte_valid   <= !head.is_end;
      run_last     <= seq_end;
      literal_done <= head.is_end;
      decode_error <= head.is_end && head.err;
    end
  end

  `JSU_ASSERT(a_idx_in_run, head_valid && !head.is_end |-> idx <= head.len_m1, "index past sequence")
  `JSU_ASSERT(a_end_shape, res_full && literal_done |-> run_last && !byte_valid, "malformed end result")

endmodule

`default_nettype wire

>>> design/json_string_unescape_utf8_top.sv
// Top level of the JSON string literal unescaper with UTF-8 output.
// Takes one byte of a quoted JSON string literal per transfer (push/full) and
// delivers decoded UTF-8 bytes plus one end-of-literal status result per
// literal (empty/pop). The parser accepts one byte every cycle while its
// 4-entry command queue has room; the emitter delivers one result per cycle
// while the receiver pops, so a \u escape that expands to 2-4 UTF-8 bytes
// holds the emitter for each of its bytes and the queue absorbs the difference.
// Each command is registered in the queue, then each result in the emitter's
// result register. Errors are sticky until the closing byte: no further bytes come out and the end result reports them.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       literal_last,
  input  wire logic       push,
  output logic            full,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            run_last,
  output logic            literal_done,
  output logic            decode_error,
  output logic            empty,
  input  wire logic       pop
);

  jsu_pkg::cmd_t cmd, head;
  logic          cmd_push, q_full, head_valid, head_pop, acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  // Parser
  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .data_byte    (data_byte),
    .literal_last (literal_last),
    .cmd          (cmd),
    .cmd_push     (cmd_push)
  );

  // Command queue
  jsu_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd),
    .q_full  (q_full),
    .rd_en   (head_pop),
    .rd_cmd  (head),
    .q_valid (head_valid)
  );

  // Byte emitter
  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .head_pop     (head_pop),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .literal_done (literal_done),
    .decode_error (decode_error),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

`default_nettype wire

>>> tb/json_string_unescape_utf8_top_tb.sv
// Self-checking testbench for the JSON string literal unescaper with UTF-8 output.
`timescale 1ns / 1ps

module json_string_unescape_utf8_top_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASE_BYTES = 90;

  // Parser position inside one literal
  typedef enum logic [3:0] {
    ST_OPEN, ST_BODY, ST_ESC, ST_HEX_HI, ST_BSL_LO, ST_U_LO, ST_HEX_LO, ST_DRAIN
  } parse_st_t;

  // Pieces a literal body is built from
  typedef enum int {
    EL_PLAIN, EL_SIMPLE_ESC, EL_U_BMP, EL_U_PAIR,
    EL_BAD_ESC, EL_BAD_HEX, EL_LONE_LOW, EL_HIGH_ALONE
  } elem_kind_t;

  // Ways a literal gets damaged
  typedef enum int {
    BRK_NONE, BRK_BAD_ELEM, BRK_NO_OPEN, BRK_TRUNC, BRK_BAD_CLOSE, BRK_ONE_BYTE
  } brk_mode_t;

  // One result transfer
  typedef struct packed {
    logic [7:0] value;
    logic       is_byte;
    logic       run_end;
    logic       done;
    logic       bad;
  } decoded_t;

  // Unescape predictor and result store
  class unescape_sb;
    parse_st_t   phase;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;
    int unsigned digits;
    bit          err_flag;
    decoded_t    pending[$];
    int unsigned mismatches;
    int unsigned bytes_in;
    int unsigned results_out;
    int unsigned literals;
    int unsigned bad_literals;
    int unsigned multi_byte_runs;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      phase    = ST_OPEN;
      hi_unit  = '0;
      lo_unit  = '0;
      digits   = 0;
      err_flag = 1'b0;
    endfunction

    function void add_out(logic [7:0] v, logic is_byte, logic run_end, logic done,
                          logic bad);
      decoded_t r;
      r.value   = v;
      r.is_byte = is_byte;
      r.run_end = run_end;
      r.done    = done;
      r.bad     = bad;
      pending.insert(pending.size(), r);
    endfunction

    // UTF-8 encoding of one code point, lead byte first
    function void add_code_point(logic [20:0] cp);
      if (cp <= 21'h7F) begin
        add_out(cp[7:0], 1'b1, 1'b1, 1'b0, 1'b0);
      end else if (cp <= 21'h7FF) begin
        add_out({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0, 1'b0);
        add_out({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, 1'b0);
      end else if (cp <= 21'hFFFF) begin
        add_out({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0, 1'b0);
        add_out({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0, 1'b0);
        add_out({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, 1'b0);
      end else begin
        add_out({5'b11110, cp[20:18]}, 1'b1, 1'b0, 1'b0, 1'b0);
        add_out({2'b10, cp[17:12]}, 1'b1, 1'b0, 1'b0, 1'b0);
        add_out({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0, 1'b0);
        add_out({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, 1'b0);
      end
      if (cp > 21'h7F) multi_byte_runs++;
    endfunction

    // Hex digit value, -1 for anything else
    function int digit_of(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b & 8'h0F);
      if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        return int'(b & 8'h07) + 9;
      return -1;
    endfunction

    function void set_error();
      err_flag = 1'b1;
      phase    = ST_DRAIN;
    endfunction

    // Predict the results of one accepted input byte
    function void note_byte(logic [7:0] b, bit fin);
      int  d;
      bit  bad;
      bytes_in++;
      if (fin) begin
        bad = err_flag || phase != ST_BODY || b != jsu_pkg::CH_QUOTE;
        add_out(8'h00, 1'b0, 1'b1, 1'b1, bad);
        literals++;
        if (bad) bad_literals++;
        clear_state();
        return;
      end
      case (phase)
        ST_OPEN: begin
          if (b != jsu_pkg::CH_QUOTE) set_error();
          else phase = ST_BODY;
        end
        ST_BODY: begin
          if (b == jsu_pkg::CH_BSL) phase = ST_ESC;
          else add_out(b, 1'b1, 1'b1, 1'b0, 1'b0);
        end
        ST_ESC: begin
          phase = ST_BODY;
          case (b)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH:
              add_out(b, 1'b1, 1'b1, 1'b0, 1'b0);
            jsu_pkg::CH_B: add_out(jsu_pkg::CH_BS, 1'b1, 1'b1, 1'b0, 1'b0);
            jsu_pkg::CH_F: add_out(jsu_pkg::CH_FF, 1'b1, 1'b1, 1'b0, 1'b0);
            jsu_pkg::CH_N: add_out(jsu_pkg::CH_LF, 1'b1, 1'b1, 1'b0, 1'b0);
            jsu_pkg::CH_R: add_out(jsu_pkg::CH_CR, 1'b1, 1'b1, 1'b0, 1'b0);
            jsu_pkg::CH_T: add_out(jsu_pkg::CH_TAB, 1'b1, 1'b1, 1'b0, 1'b0);
            jsu_pkg::CH_U: begin
              phase   = ST_HEX_HI;
              hi_unit = '0;
              digits  = 0;
            end
            default: set_error();
          endcase
        end
        ST_HEX_HI: begin
          d = digit_of(b);
          if (d < 0) begin
            set_error();
          end else begin
            hi_unit = {hi_unit[11:0], 4'(d)};
            digits++;
            if (digits == 4) begin
              digits = 0;
              if (hi_unit >= jsu_pkg::HI_SURR_MIN && hi_unit <= jsu_pkg::HI_SURR_MAX) begin
                phase = ST_BSL_LO;
              end else if (hi_unit >= jsu_pkg::LO_SURR_MIN &&
                           hi_unit <= jsu_pkg::LO_SURR_MAX) begin
                set_error();
              end else begin
                phase = ST_BODY;
                add_code_point({5'd0, hi_unit});
              end
            end
          end
        end
        ST_BSL_LO: begin
          if (b != jsu_pkg::CH_BSL) set_error();
          else phase = ST_U_LO;
        end
        ST_U_LO: begin
          if (b != jsu_pkg::CH_U) begin
            set_error();
          end else begin
            phase   = ST_HEX_LO;
            lo_unit = '0;
            digits  = 0;
          end
        end
        ST_HEX_LO: begin
          d = digit_of(b);
          if (d < 0) begin
            set_error();
          end else begin
            lo_unit = {lo_unit[11:0], 4'(d)};
            digits++;
            if (digits == 4) begin
              digits = 0;
              if (lo_unit < jsu_pkg::LO_SURR_MIN || lo_unit > jsu_pkg::LO_SURR_MAX) begin
                set_error();
              end else begin
                // high unit is known to be a high surrogate here
                phase = ST_BODY;
                add_code_point(21'h10000 + {1'b0, hi_unit[9:0], lo_unit[9:0]});
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    // Compare one result transfer against the oldest prediction
    task check_result(logic [7:0] ob, logic bv, logic rl, logic ld, logic de);
      decoded_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h valid=%b last=%b done=%b err=%b",
                                  ob, bv, rl, ld, de));
        return;
      end
      want = pending.pop_front();
      results_out++;
      if (ob !== want.value || bv !== want.is_byte || rl !== want.run_end ||
          ld !== want.done || de !== want.bad) begin
        report_mismatch($sformatf(
          "result %0d: got %02h/%b/%b/%b/%b want %02h/%b/%b/%b/%b (byte/valid/last/done/err)",
          results_out, ob, bv, rl, ld, de,
          want.value, want.is_byte, want.run_end, want.done, want.bad));
      end
    endtask
  endclass

  logic       clk;
  logic       rst          = 1'b1;
  logic [7:0] data_byte    = 8'h00;
  logic       literal_last = 1'b0;
  logic       push         = 1'b0;
  logic       pop          = 1'b0;
  logic       full;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       literal_done;
  logic       decode_error;
  logic       empty;

  unescape_sb  sb;
  logic [7:0]  lit[$];
  logic [7:0]  esc_letters[8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH,
                                  jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                                  jsu_pkg::CH_R, jsu_pkg::CH_T};
  logic [15:0] bound_units[8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                  16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        rx_hold        = 1'b0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned full_cycles    = 0;

  json_string_unescape_utf8_top dut (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .literal_last (literal_last),
    .push         (push),
    .full         (full),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .literal_done (literal_done),
    .decode_error (decode_error),
    .empty        (empty),
    .pop          (pop)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle count, time limit, input back-pressure count
  always @(posedge clk) begin
    cycle_count++;
    if (full) full_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending.size());
      $display("json_string_unescape_utf8_top_tb: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, forced off during a hold
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Result transfers
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_result(out_byte, byte_valid, run_last, literal_done, decode_error);
  end

  // Offer one byte, with random idle cycles first, until it transfers
  task automatic send_byte(input logic [7:0] b, input bit fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    data_byte    <= b;
    literal_last <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_literal();
    for (int i = 0; i < lit.size(); i++) send_byte(lit[i], i == lit.size() - 1);
  endtask

  // Append one byte to the literal under construction
  task automatic lit_add(input logic [7:0] b);
    lit.insert(lit.size(), b);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'd0, n - 4'd10};
  endfunction

  function automatic logic [15:0] high_surrogate();
    if ($urandom_range(3) == 0)
      return $urandom_range(1) ? jsu_pkg::HI_SURR_MAX : jsu_pkg::HI_SURR_MIN;
    return 16'($urandom_range(jsu_pkg::HI_SURR_MIN, jsu_pkg::HI_SURR_MAX));
  endfunction

  function automatic logic [15:0] low_surrogate();
    if ($urandom_range(3) == 0)
      return $urandom_range(1) ? jsu_pkg::LO_SURR_MAX : jsu_pkg::LO_SURR_MIN;
    return 16'($urandom_range(jsu_pkg::LO_SURR_MIN, jsu_pkg::LO_SURR_MAX));
  endfunction

  // Non-surrogate code unit spread over 1, 2 and 3 byte encodings
  function automatic logic [15:0] bmp_unit();
    logic [15:0] u;
    case ($urandom_range(3))
      0: u = 16'($urandom_range(16'h007F));
      1: u = 16'($urandom_range(16'h0080, 16'h07FF));
      2: begin
        do u = 16'($urandom_range(16'h0800, 16'hFFFF));
        while (u >= jsu_pkg::HI_SURR_MIN && u <= jsu_pkg::LO_SURR_MAX);
      end
      default: u = bound_units[$urandom_range(7)];
    endcase
    return u;
  endfunction

  task automatic add_unit(input logic [15:0] u);
    lit_add(jsu_pkg::CH_BSL);
    lit_add(jsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--) lit_add(hex_char(u[i*4 +: 4]));
  endtask

  function automatic logic [7:0] any_but(input logic [7:0] skip);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == skip);
    return b;
  endfunction

  // Append one body element; bad elements break the escape grammar
  task automatic add_element(input bit bad);
    int         roll;
    elem_kind_t kind;
    logic [7:0] b;
    roll = $urandom_range(9);
    if (bad) kind = elem_kind_t'($urandom_range(EL_BAD_ESC, EL_HIGH_ALONE));
    else if (roll < 4) kind = EL_PLAIN;
    else if (roll < 6) kind = EL_SIMPLE_ESC;
    else if (roll < 9) kind = EL_U_BMP;
    else kind = EL_U_PAIR;
    case (kind)
      EL_PLAIN: lit_add(any_but(jsu_pkg::CH_BSL));
      EL_SIMPLE_ESC: begin
        lit_add(jsu_pkg::CH_BSL);
        lit_add(esc_letters[$urandom_range(7)]);
      end
      EL_U_BMP: add_unit(bmp_unit());
      EL_U_PAIR: begin
        add_unit(high_surrogate());
        add_unit(low_surrogate());
      end
      EL_BAD_ESC: begin
        lit_add(jsu_pkg::CH_BSL);
        do b = 8'($urandom_range(255));
        while (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH,
                         jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                         jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_U});
        lit_add(b);
      end
      EL_BAD_HEX: begin
        lit_add(jsu_pkg::CH_BSL);
        lit_add(jsu_pkg::CH_U);
        repeat ($urandom_range(3)) lit_add(hex_char(4'($urandom_range(15))));
        do b = 8'($urandom_range(255));
        while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
        lit_add(b);
      end
      EL_LONE_LOW: add_unit(low_surrogate());
      default: begin
        // high surrogate followed by something other than a low one
        add_unit(high_surrogate());
        case ($urandom_range(2))
          0: lit_add(any_but(jsu_pkg::CH_BSL));
          1: begin
            lit_add(jsu_pkg::CH_BSL);
            lit_add(any_but(jsu_pkg::CH_U));
          end
          default: add_unit($urandom_range(1) ? bmp_unit() : high_surrogate());
        endcase
      end
    endcase
  endtask

  // Mostly well-formed literals with random content, some damaged
  task automatic build_literal();
    int        n;
    int        bad_at;
    int        cut;
    int        r;
    brk_mode_t mode;
    lit.delete();
    mode = BRK_NONE;
    if ($urandom_range(99) < 18) begin
      r = $urandom_range(1, 7);
      mode = (r > 5) ? BRK_BAD_ELEM : brk_mode_t'(r);
    end
    if (mode == BRK_ONE_BYTE) begin
      lit_add(8'($urandom_range(255)));
      return;
    end
    n = $urandom_range(7);
    bad_at = $urandom_range(n);
    lit_add(mode == BRK_NO_OPEN ? any_but(jsu_pkg::CH_QUOTE) : jsu_pkg::CH_QUOTE);
    for (int i = 0; i <= n; i++) begin
      if (mode == BRK_BAD_ELEM && i == bad_at) add_element(1'b1);
      if (i < n) add_element(1'b0);
    end
    lit_add(mode == BRK_BAD_CLOSE ? 8'($urandom_range(255)) : jsu_pkg::CH_QUOTE);
    if (mode == BRK_TRUNC) begin
      cut = $urandom_range(1, lit.size() - 1);
      while (lit.size() > cut) void'(lit.pop_back());
    end
  endtask

  task automatic run_phase(input int sidle, input int rstall, input int quota);
    int unsigned start;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      build_literal();
      send_literal();
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: too short, missing open quote, surrogate pair, top of the BMP
    lit = '{jsu_pkg::CH_QUOTE};
    send_literal();
    lit = '{8'h41, jsu_pkg::CH_QUOTE};
    send_literal();
    // "\uD83D\uDE00"
    lit = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_U, 8'h44, 8'h38, 8'h33, 8'h44,
            jsu_pkg::CH_BSL, jsu_pkg::CH_U, 8'h44, 8'h45, 8'h30, 8'h30, jsu_pkg::CH_QUOTE};
    send_literal();
    // "\ufFFf"
    lit = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_U, 8'h66, 8'h46, 8'h46, 8'h66,
            jsu_pkg::CH_QUOTE};
    send_literal();

    // Random literals under each idle mix
    run_phase(0, 0, PHASE_BYTES);
    run_phase(79, 0, PHASE_BYTES);
    run_phase(0, 79, PHASE_BYTES);
    run_phase(15, 15, PHASE_BYTES);

    // Long receiver hold while bytes keep coming: input must stall
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    run_phase(0, 0, 40);
    @(negedge clk) push <= 1'b0;

    // Drain, then watch a few more cycles for stray results
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d bytes in %0d literals (%0d malformed), %0d results checked",
             sb.bytes_in, sb.literals, sb.bad_literals, sb.results_out);
    $display("%0d multi-byte UTF-8 sequences; input held off for %0d cycles; %0d mismatches",
             sb.multi_byte_runs, full_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("json_string_unescape_utf8_top_tb: done, clean");
    end else begin
      $display("json_string_unescape_utf8_top_tb: done, errors");
    end
    $finish;
  end

endmodule
